// ===== src/abrzc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package abrzc_pkg;

    // Fixed widths of the sample path and of the bucket bookkeeping.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BUCKETS = 4096;
    localparam int SUM_W       = 54;
    localparam int CNT_W       = 24;
    localparam int IDX_W       = 12;
    localparam int DONE_W      = 13;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd2;

    // 0.7 in Q0.16.
    localparam logic [15:0] FRAC_POINT_SEVEN = 16'd45875;

    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic [CNT_W-1:0] crossings;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] index;
    } t_job;

    typedef struct packed {
        logic [IDX_W-1:0] bucket_index;
        logic [OUT_W-1:0] amplitude;
        logic [OUT_W-1:0] low_band;
        logic [OUT_W-1:0] mid_band;
        logic [OUT_W-1:0] high_band;
    } t_result;

endpackage

`default_nettype wire

// ===== src/abrzc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface abrzc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [abrzc_pkg::SAMPLE_BITS-1:0] left_sample;
    logic signed [abrzc_pkg::SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

// ===== src/abrzc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface abrzc_out_if;
    logic                          valid;
    logic                          ready;
    logic [abrzc_pkg::IDX_W-1:0]   bucket_index;
    logic [abrzc_pkg::OUT_W-1:0]   amplitude;
    logic [abrzc_pkg::OUT_W-1:0]   low_band;
    logic [abrzc_pkg::OUT_W-1:0]   mid_band;
    logic [abrzc_pkg::OUT_W-1:0]   high_band;

    modport source (
        output valid, output bucket_index, output amplitude, output low_band,
        output mid_band, output high_band, input ready
    );
    modport sink (
        input valid, input bucket_index, input amplitude, input low_band,
        input mid_band, input high_band, output ready
    );
endinterface

`default_nettype wire

// ===== src/audio_bucket_rms_zero_crossing.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bucketed loudness and zero-crossing analyser for 16-bit PCM audio. Each request carries one
// frame; in stereo mode the two channels are mixed to mono as floor((L+R)/2), otherwise the
// left sample is used alone. Mono samples are gathered into buckets of bucket_length samples,
// and for each full bucket one result is sent: the bucket number, the amplitude (three times
// the RMS, saturated to Q0.16), and three band levels derived from the amplitude and the
// zero-crossing rate. Once bucket_total buckets have been produced, further frames are
// accepted and dropped until the total is raised or the block is reset; a dropped frame leaves
// the block idle for the next request. Configuration must be written only while the block is
// idle; the block itself does not enforce this. A frame that does not close a bucket passes
// through accept, square and accumulate before the next request is taken. A frame that closes
// a bucket then waits on the shared compare-and-subtract unit: 32 steps of the mean-square
// division, 16 of the square root and 16 of the crossing-rate division, with a set-up step
// before each division, then the band levels on the shared multiplier and a final step to
// hand the result to the output register. While the previous result still waits in the
// output register, the input is held off for longer. Saturated amplitudes or crossing rates
// skip their steps and finish sooner.

module audio_bucket_rms_zero_crossing (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [abrzc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [abrzc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    abrzc_in_if.sink                              i_in,
    abrzc_out_if.source                           o_out
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ACCUM  = 4'b0100,
        ST_WAIT   = 4'b1000
    } t_state;

    localparam logic [abrzc_pkg::DONE_W-1:0] MAX_TOTAL =
        abrzc_pkg::DONE_W'(abrzc_pkg::MAX_BUCKETS);

    // Configuration registers.
    logic                            r_stereo;
    logic [abrzc_pkg::CNT_W-1:0]     r_len;
    logic [abrzc_pkg::DONE_W-1:0]    r_total;

    // Bucket state.
    t_state                          r_state;
    logic [abrzc_pkg::SUM_W-1:0]     r_sum;
    logic [abrzc_pkg::CNT_W-1:0]     r_cross;
    logic [abrzc_pkg::CNT_W-1:0]     r_pos;
    logic signed [15:0]              r_prev;
    logic [abrzc_pkg::DONE_W-1:0]    r_done;

    // Per-frame pipeline registers.
    logic signed [15:0]              r_mono;
    logic [30:0]                     r_sq;

    // Output register.
    logic                            r_out_valid;
    abrzc_pkg::t_result              r_out;

    logic                            in_acc;
    logic [abrzc_pkg::DONE_W-1:0]    total_eff;
    logic [abrzc_pkg::CNT_W-1:0]     len_eff;
    logic signed [16:0]              mix;
    logic signed [15:0]              mono;
    logic signed [31:0]              sq_full;
    logic                            cross_now;
    logic [abrzc_pkg::SUM_W-1:0]     n_sum;
    logic [abrzc_pkg::CNT_W-1:0]     n_pos;
    logic                            bucket_end;

    logic                            eng_start;
    abrzc_pkg::t_job                 eng_job;
    logic                            eng_valid;
    abrzc_pkg::t_result              eng_res;
    logic                            res_load;

    // A request is only taken between frames; each accepted frame runs to completion.
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // A zero length behaves as one, and the total is capped at the bucket limit.
    assign total_eff = (r_total > MAX_TOTAL) ? MAX_TOTAL : r_total;
    assign len_eff   = (r_len == '0) ? abrzc_pkg::CNT_W'(1) : r_len;

    // The arithmetic shift of the 17-bit sum gives floor((L+R)/2), which always fits 16 bits.
    assign mix  = {i_in.left_sample[15], i_in.left_sample}
                + {i_in.right_sample[15], i_in.right_sample};
    assign mono = r_stereo ? mix[16:1] : i_in.left_sample;

    assign sq_full = $signed({{16{r_mono[15]}}, r_mono}) * $signed({{16{r_mono[15]}}, r_mono});

    // A crossing is a change between positive and non-positive; the first sample of a bucket
    // has no neighbour and never counts.
    assign cross_now = (r_pos != '0)
                    && ((!r_mono[15] && (r_mono != '0)) != (!r_prev[15] && (r_prev != '0)));

    assign n_sum      = r_sum + {23'd0, r_sq};
    assign n_pos      = r_pos + abrzc_pkg::CNT_W'(1);
    assign bucket_end = (n_pos >= len_eff);

    assign eng_start         = (r_state == ST_ACCUM) && bucket_end;
    assign eng_job.square_sum = n_sum;
    assign eng_job.crossings  = r_cross;
    assign eng_job.count      = n_pos;
    assign eng_job.index      = r_done[abrzc_pkg::IDX_W-1:0];

    assign res_load = eng_valid && (!r_out_valid || o_out.ready);

    abrzc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (eng_start),
        .i_job       (eng_job),
        .o_res_valid (eng_valid),
        .o_res       (eng_res),
        .i_res_ready (res_load)
    );

    // Configuration writes to an index outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo <= 1'b0;
            r_len    <= abrzc_pkg::CNT_W'(1);
            r_total  <= abrzc_pkg::DONE_W'(2048);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                abrzc_pkg::CFG_STEREO: r_stereo <= i_cfg_data[0];
                abrzc_pkg::CFG_LENGTH: r_len    <= i_cfg_data;
                abrzc_pkg::CFG_TOTAL:  r_total  <= i_cfg_data[abrzc_pkg::DONE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_cross <= '0;
            r_pos   <= '0;
            r_prev  <= '0;
            r_done  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    // Once the bucket total is reached the frame is taken and dropped.
                    if (in_acc && (r_done < total_eff)) begin
                        r_state <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    if (cross_now) begin
                        r_cross <= r_cross + abrzc_pkg::CNT_W'(1);
                    end
                    r_prev  <= r_mono;
                    r_state <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    if (bucket_end) begin
                        r_sum   <= '0;
                        r_cross <= '0;
                        r_pos   <= '0;
                        r_done  <= r_done + abrzc_pkg::DONE_W'(1);
                        r_state <= ST_WAIT;
                    end else begin
                        r_sum   <= n_sum;
                        r_pos   <= n_pos;
                        r_state <= ST_IDLE;
                    end
                end
                ST_WAIT: begin
                    if (res_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mono <= mono;
        end
        if (r_state == ST_SQUARE) begin
            r_sq <= sq_full[30:0];
        end
        if (res_load) begin
            r_out <= eng_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.bucket_index = r_out.bucket_index;
    assign o_out.amplitude    = r_out.amplitude;
    assign o_out.low_band     = r_out.low_band;
    assign o_out.mid_band     = r_out.mid_band;
    assign o_out.high_band    = r_out.high_band;

endmodule

`default_nettype wire

// ===== src/abrzc_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abrzc_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  abrzc_pkg::t_job    i_job,
    output logic               o_res_valid,
    output abrzc_pkg::t_result o_res,
    input  logic               i_res_ready
);

    typedef enum logic [10:0] {
        E_IDLE  = 11'b000_0000_0001,
        E_PREP  = 11'b000_0000_0010,
        E_DIVX  = 11'b000_0000_0100,
        E_SQRT  = 11'b000_0000_1000,
        E_FPREP = 11'b000_0001_0000,
        E_DIVF  = 11'b000_0010_0000,
        E_MUL0  = 11'b000_0100_0000,
        E_MUL1  = 11'b000_1000_0000,
        E_MUL2  = 11'b001_0000_0000,
        E_MUL3  = 11'b010_0000_0000,
        E_DONE  = 11'b100_0000_0000
    } t_estate;

    t_estate r_state;
    logic [4:0] r_step;

    logic [abrzc_pkg::SUM_W-1:0] r_sum;
    logic [abrzc_pkg::CNT_W-1:0] r_cross;
    logic [abrzc_pkg::CNT_W-1:0] r_n;
    logic [abrzc_pkg::IDX_W-1:0] r_index;
    logic [abrzc_pkg::CNT_W-1:0] r_rem;
    logic [31:0]                 r_q;
    logic [15:0]                 r_root;
    logic                        r_fsat;
    logic [49:0]                 r_prod;
    logic [32:0]                 r_w;
    logic [15:0]                 r_high;
    logic [15:0]                 r_low;

    logic [59:0] dvd;
    logic        x_sat;
    logic [27:0] ten_c;
    logic        f_sat;
    logic [16:0] f17;

    logic [25:0] su_a;
    logic [25:0] su_b;
    logic [26:0] su_x;
    logic [25:0] su_diff;
    logic        su_ge;

    logic [16:0] mul_a;
    logic [32:0] mul_b;
    logic [49:0] mul_p;

    // 36 times the sum of squares; the quotient by n saturates once it reaches 2^32.
    assign dvd   = {1'b0, r_sum, 5'd0} + {4'd0, r_sum, 2'd0};
    assign x_sat = dvd[59:32] >= {4'd0, r_n};

    assign ten_c = {1'b0, r_cross, 3'd0} + {3'd0, r_cross, 1'b0};
    assign f_sat = ten_c >= {4'd0, r_n};
    assign f17   = r_fsat ? 17'h10000 : {1'b0, r_q[15:0]};

    // The one compare-and-subtract unit, shared by both divisions and the square root.
    always_comb begin
        if (r_state == E_SQRT) begin
            su_a = {r_rem, r_q[31:30]};
            su_b = {8'd0, r_root, 2'b01};
        end else begin
            su_a = {1'b0, r_rem, r_q[31]};
            su_b = {2'd0, r_n};
        end
    end

    assign su_x    = {1'b0, su_a} - {1'b0, su_b};
    assign su_diff = su_x[25:0];
    assign su_ge   = ~su_x[26];

    always_comb begin
        mul_a = {1'b0, r_root};
        mul_b = r_w;
        case (r_state)
            E_MUL0: begin
                mul_a = f17;
                mul_b = {17'd0, abrzc_pkg::FRAC_POINT_SEVEN};
            end
            E_MUL1: begin
                mul_b = {16'd0, f17};
            end
            default: begin
            end
        endcase
    end

    assign mul_p = {33'd0, mul_a} * {17'd0, mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_state <= E_PREP;
                    end
                end
                E_PREP: begin
                    r_step  <= 5'd31;
                    r_state <= x_sat ? E_FPREP : E_DIVX;
                end
                E_DIVX: begin
                    if (r_step == '0) begin
                        r_step  <= 5'd15;
                        r_state <= E_SQRT;
                    end else begin
                        r_step <= r_step - 5'd1;
                    end
                end
                E_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= E_FPREP;
                    end else begin
                        r_step <= r_step - 5'd1;
                    end
                end
                E_FPREP: begin
                    r_step  <= 5'd15;
                    r_state <= f_sat ? E_MUL0 : E_DIVF;
                end
                E_DIVF: begin
                    if (r_step == '0) begin
                        r_state <= E_MUL0;
                    end else begin
                        r_step <= r_step - 5'd1;
                    end
                end
                E_MUL0: begin
                    r_state <= E_MUL1;
                end
                E_MUL1: begin
                    r_state <= E_MUL2;
                end
                E_MUL2: begin
                    r_state <= E_MUL3;
                end
                E_MUL3: begin
                    r_state <= E_DONE;
                end
                E_DONE: begin
                    if (i_res_ready) begin
                        r_state <= E_IDLE;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    r_sum   <= i_job.square_sum;
                    r_cross <= i_job.crossings;
                    r_n     <= i_job.count;
                    r_index <= i_job.index;
                end
            end
            E_PREP: begin
                if (x_sat) begin
                    r_root <= 16'hFFFF;
                end else begin
                    r_rem <= dvd[55:32];
                    r_q   <= dvd[31:0];
                end
            end
            E_DIVX: begin
                r_q <= {r_q[30:0], su_ge};
                if (r_step == '0) begin
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_rem <= su_ge ? su_diff[23:0] : su_a[23:0];
                end
            end
            E_SQRT: begin
                r_rem  <= su_ge ? su_diff[23:0] : su_a[23:0];
                r_q    <= {r_q[29:0], 2'b00};
                r_root <= {r_root[14:0], su_ge};
            end
            E_FPREP: begin
                r_fsat <= f_sat;
                r_rem  <= ten_c[23:0];
                r_q    <= '0;
            end
            E_DIVF: begin
                r_rem <= su_ge ? su_diff[23:0] : su_a[23:0];
                r_q   <= {r_q[30:0], su_ge};
            end
            E_MUL0: begin
                r_prod <= mul_p;
            end
            E_MUL1: begin
                r_w    <= 33'h1_0000_0000 - r_prod[32:0];
                r_prod <= mul_p;
            end
            E_MUL2: begin
                r_high <= r_prod[31:16];
                r_prod <= mul_p;
            end
            E_MUL3: begin
                r_low <= r_prod[47:32];
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid        = (r_state == E_DONE);
    assign o_res.bucket_index = r_index;
    assign o_res.amplitude    = r_root;
    assign o_res.low_band     = r_low;
    assign o_res.mid_band     = {1'b0, r_root[15:1]};
    assign o_res.high_band    = r_high;

endmodule

`default_nettype wire

// ===== src/abrzc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abrzc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [abrzc_pkg::IDX_W-1:0] i_bucket_index,
    input logic [abrzc_pkg::OUT_W-1:0] i_amplitude,
    input logic [abrzc_pkg::OUT_W-1:0] i_low_band,
    input logic [abrzc_pkg::OUT_W-1:0] i_mid_band,
    input logic [abrzc_pkg::OUT_W-1:0] i_high_band
);

    // A stalled result stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bucket_index)
            && $stable(i_amplitude) && $stable(i_low_band) && $stable(i_mid_band)
            && $stable(i_high_band))
        else $error("result changed while stalled");

    // The handshake signals are always driven to known levels out of reset.
    a_handshake_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_in_valid, i_in_ready, i_out_valid, i_out_ready}))
        else $error("handshake signal unknown");

    a_mid_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_mid_band == {1'b0, i_amplitude[15:1]})
        else $error("mid band is not half the amplitude");

    // Both weighted bands scale the amplitude by a factor of at most one.
    a_bands_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_high_band <= i_amplitude) && (i_low_band <= i_amplitude))
        else $error("band level above amplitude");

endmodule

bind audio_bucket_rms_zero_crossing abrzc_checker u_abrzc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_bucket_index (o_out.bucket_index),
    .i_amplitude    (o_out.amplitude),
    .i_low_band     (o_out.low_band),
    .i_mid_band     (o_out.mid_band),
    .i_high_band    (o_out.high_band)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bucketed RMS and zero-crossing analyser.
// A driver process presents PCM frames from a queue of pending frames, and every request the
// block takes is run at once through a predictor that keeps its own copy of the bucket state
// and of the three registers. A monitor process compares each bucket result the block sends
// with the oldest prediction, field by field.
module tb;
    import abrzc_pkg::*;

    localparam int SETTLE_CYCLES    = 120;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int RANDOM_PHASES    = 12;
    localparam int FRAMES_PER_PHASE = 96;
    localparam int REPORT_LIMIT     = 10;

    // Shapes of sample content used to fill a phase.
    typedef enum int {
        STYLE_FULL,
        STYLE_QUIET,
        STYLE_ALTERNATING,
        STYLE_EXTREME,
        STYLE_LOUD
    } t_sample_style;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } t_pcm_frame;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    abrzc_in_if  frame_if ();
    abrzc_out_if bucket_if ();

    audio_bucket_rms_zero_crossing uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (frame_if),
        .o_out      (bucket_if)
    );

    // Our copy of the registers, updated as each write is issued. Writes only happen while
    // the block is idle, so the copy never runs ahead of a frame still in flight.
    logic                  mix_stereo;
    logic [23:0]           bucket_len_cfg;
    logic [12:0]           bucket_total_cfg;

    // Our copy of the bucket state.
    longint unsigned       energy_sum;
    int unsigned           crossings_seen;
    int unsigned           frames_in_bucket;
    logic signed [15:0]    prev_mono;
    int unsigned           buckets_closed;

    t_pcm_frame            frames_pending[$];
    t_result               bucket_results_due[$];

    // Frames handed to the driver and frames the block has taken. Comparing counts rather
    // than looking at the queue keeps the idle test free of ordering races at the edge.
    int unsigned           frames_queued = 0;
    int unsigned           frames_taken = 0;
    int unsigned           mismatch_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;
    logic                  hold_off_start;
    int unsigned           hold_off_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Integer square root, one result bit at a time from the top.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Advances our bucket state by one taken frame and, when the frame closes a bucket,
    // queues the result the block must send for it.
    task automatic take_frame(input logic signed [15:0] left, input logic signed [15:0] right);
        int unsigned        total_eff;
        int unsigned        len_eff;
        int unsigned        n;
        logic signed [16:0] mix;
        logic signed [15:0] mono;
        longint signed      wide_mono;
        longint unsigned    crossings64;
        longint unsigned    mean_sq;
        longint unsigned    amp;
        longint unsigned    freq;
        longint unsigned    weight;
        t_result            res;

        // A total above the bucket store's size behaves as the size; a length of zero as one.
        total_eff = (bucket_total_cfg > MAX_BUCKETS) ? MAX_BUCKETS : bucket_total_cfg;
        len_eff   = (bucket_len_cfg == 0) ? 1 : bucket_len_cfg;

        // Once the bucket total is reached, frames are dropped without touching any state.
        if (buckets_closed >= total_eff) begin
            return;
        end

        // The stereo mix floors towards minus infinity, which is an arithmetic shift.
        mix  = left + right;
        mono = mix_stereo ? mix[16:1] : left;

        wide_mono  = mono;
        energy_sum = energy_sum + longint'(wide_mono * wide_mono);

        // A crossing is a change between positive and not positive; the first sample of a
        // bucket never counts, though the previous sample carries over from the last bucket.
        if (frames_in_bucket > 0 && ((mono > 0) != (prev_mono > 0))) begin
            crossings_seen++;
        end
        prev_mono = mono;
        frames_in_bucket++;

        // A length lowered below the samples already held closes the bucket here, with n
        // being the number of samples it really holds.
        if (frames_in_bucket < len_eff) begin
            return;
        end

        n = frames_in_bucket;

        // Nine times the mean square, scaled into Q0.16 squared, split so that nothing
        // overflows: 36 * S / n for 16-bit samples.
        mean_sq = (energy_sum / n) * 36 + ((energy_sum % n) * 36) / n;
        amp     = floor_sqrt(mean_sq);
        if (amp > 65535) begin
            amp = 65535;
        end

        crossings64 = crossings_seen;
        if (crossings64 * 10 >= n) begin
            freq = 65536;
        end else begin
            freq = (crossings64 * 10 * 65536) / n;
        end
        weight = (64'd1 << 32) - FRAC_POINT_SEVEN * freq;

        res.bucket_index = buckets_closed[IDX_W-1:0];
        res.amplitude    = amp[15:0];
        res.low_band     = 16'((amp * weight) >> 32);
        res.mid_band     = amp[16:1];
        res.high_band    = 16'((amp * freq) >> 16);
        bucket_results_due.push_back(res);

        energy_sum       = 0;
        crossings_seen   = 0;
        frames_in_bucket = 0;
        buckets_closed++;
    endtask

    // Sample for a phase of the given style; k is the frame number within the phase.
    function automatic logic signed [15:0] make_sample(input t_sample_style style,
                                                       input int unsigned k);
        int unsigned mag;
        int          v;
        case (style)
            STYLE_FULL: begin
                return 16'($urandom);
            end
            STYLE_QUIET: begin
                v = int'($urandom_range(512)) - 256;
                return 16'(v);
            end
            STYLE_ALTERNATING: begin
                if ($urandom_range(7) == 0) begin
                    return 16'sd0;
                end
                mag = $urandom_range(32767, 1);
                return k[0] ? 16'(mag) : -16'(mag);
            end
            STYLE_EXTREME: begin
                case ($urandom_range(4))
                    0: return 16'sh8000;
                    1: return 16'shFFFF;
                    2: return 16'sh0000;
                    3: return 16'sh0001;
                    default: return 16'sh7FFF;
                endcase
            end
            default: begin
                mag = $urandom_range(32767, 20000);
                return $urandom_range(1) ? 16'(mag) : -16'(mag);
            end
        endcase
    endfunction

    task automatic queue_frame(input logic signed [15:0] left, input logic signed [15:0] right);
        t_pcm_frame f;
        f.left  = left;
        f.right = right;
        frames_pending.push_back(f);
        frames_queued++;
    endtask

    // Register writes are mirrored into our copy straight away.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_STEREO: mix_stereo       = value[0];
            CFG_LENGTH: bucket_len_cfg   = value[23:0];
            CFG_TOTAL:  bucket_total_cfg = value[12:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued frame has been taken and every predicted bucket has arrived,
    // then lets the block finish any frame that closed no bucket before the next write.
    task automatic wait_idle();
        while (frames_taken != frames_queued || bucket_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: each taken request goes through the predictor before the next frame is put up.
    always @(posedge i_clk) begin
        t_pcm_frame next_frame;
        if (!i_rst_n) begin
            frame_if.valid <= 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                take_frame(frame_if.left_sample, frame_if.right_sample);
                frames_taken++;
            end
            if (!frame_if.valid || frame_if.ready) begin
                if (frames_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_frame = frames_pending.pop_front();
                    frame_if.valid        <= 1'b1;
                    frame_if.left_sample  <= next_frame.left;
                    frame_if.right_sample <= next_frame.right;
                end else begin
                    frame_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side, counted down here so that the sender keeps going.
    always @(posedge i_clk) begin
        if (hold_off_start) begin
            hold_off_left <= HOLD_OFF_CYCLES;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    always @(posedge i_clk) begin
        bucket_if.ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: every result taken must match the oldest prediction in every field.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && bucket_if.valid && bucket_if.ready) begin
            if (bucket_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result for bucket %0d", bucket_if.bucket_index);
                end
            end else begin
                want = bucket_results_due.pop_front();
                if (want.bucket_index !== bucket_if.bucket_index ||
                    want.amplitude    !== bucket_if.amplitude ||
                    want.low_band     !== bucket_if.low_band ||
                    want.mid_band     !== bucket_if.mid_band ||
                    want.high_band    !== bucket_if.high_band) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected idx %0d amp %0d low %0d mid %0d high %0d",
                                 want.bucket_index, want.amplitude, want.low_band,
                                 want.mid_band, want.high_band);
                        $display("          got      idx %0d amp %0d low %0d mid %0d high %0d",
                                 bucket_if.bucket_index, bucket_if.amplitude,
                                 bucket_if.low_band, bucket_if.mid_band, bucket_if.high_band);
                    end
                end
            end
        end
    end

    // Watchdog: a block that hangs or stops answering ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int unsigned   len_pick;
        t_sample_style style;

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        frame_if.valid         = 1'b0;
        frame_if.left_sample   = '0;
        frame_if.right_sample  = '0;
        bucket_if.ready        = 1'b0;
        hold_off_start         = 1'b0;
        send_idle_pct          = 10;
        recv_idle_pct          = 62;

        mix_stereo       = 1'b0;
        bucket_len_cfg   = 24'd1;
        bucket_total_cfg = 13'd2048;
        energy_sum       = 0;
        crossings_seen   = 0;
        frames_in_bucket = 0;
        prev_mono        = '0;
        buckets_closed   = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset: left channel only, one sample per bucket. Full-scale samples
        // saturate the amplitude; zero gives silence.
        queue_frame(16'sh7FFF, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7FFF);
        queue_frame(16'sh0000, 16'sh0000);
        queue_frame(16'shFFFF, 16'sh0001);
        queue_frame(16'sh0001, 16'shFFFF);
        wait_idle();

        // Stereo mix with buckets of four: the extremes of both channels, a mix that floors
        // to minus one, and then a bucket that crosses zero at every sample.
        write_reg(CFG_STEREO, 1);
        write_reg(CFG_LENGTH, 4);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh8000, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7FFF);
        queue_frame(16'sd1, 16'sd0);
        queue_frame(16'sd1000, 16'sd1200);
        queue_frame(-16'sd900, -16'sd1100);
        queue_frame(16'sd700, 16'sd900);
        queue_frame(16'sd0, -16'sd1);
        wait_idle();

        // The longest bucket only ever holds a partial bucket, which must send nothing.
        // Lowering the length below the samples held then closes it on the next frame.
        write_reg(CFG_STEREO, 0);
        write_reg(CFG_LENGTH, 24'hFFFFFF);
        queue_frame(16'sd12000, 16'sd0);
        queue_frame(-16'sd12000, 16'sd0);
        queue_frame(16'sd5, 16'sd0);
        wait_idle();
        write_reg(CFG_LENGTH, 2);
        queue_frame(-16'sd7, 16'sd0);
        wait_idle();

        // A length of zero behaves as one.
        write_reg(CFG_LENGTH, 0);
        queue_frame(16'sd300, 16'sd0);
        queue_frame(-16'sd300, 16'sd0);
        wait_idle();

        // Reaching the bucket total: two more buckets, then frames are dropped.
        write_reg(CFG_TOTAL, buckets_closed + 2);
        queue_frame(16'sd4000, 16'sd0);
        queue_frame(16'sd5000, 16'sd0);
        queue_frame(16'sd6000, 16'sd0);
        queue_frame(16'sd7000, 16'sd0);
        wait_idle();

        // A total of zero drops everything.
        write_reg(CFG_TOTAL, 0);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh8000, 16'sh8000);
        wait_idle();

        // The widest total acts as the size of the bucket store.
        write_reg(CFG_TOTAL, 13'h1FFF);

        // Random phases: a third with the sender idling lightly and the receiver heavily,
        // a third the other way round, and a third with no idling at all.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < RANDOM_PHASES / 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 62;
            end else if (p < 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p == 2 * RANDOM_PHASES / 3) begin
                write_reg(CFG_TOTAL, MAX_BUCKETS);
            end

            // Mostly short buckets so results stay frequent; now and then a long one, which
            // may be left part-filled and then cut short by the next phase's length.
            len_pick = $urandom_range(9);
            case (len_pick) inside
                [0:2]:   write_reg(CFG_LENGTH, 1);
                [3:4]:   write_reg(CFG_LENGTH, $urandom_range(4, 2));
                [5:6]:   write_reg(CFG_LENGTH, $urandom_range(16, 5));
                7:       write_reg(CFG_LENGTH, $urandom_range(64, 17));
                8:       write_reg(CFG_LENGTH, 0);
                default: write_reg(CFG_LENGTH, $urandom_range(400, 200));
            endcase
            write_reg(CFG_STEREO, $urandom_range(1));
            style = t_sample_style'($urandom_range(4));

            // One phase with a bucket per frame while the receiver holds off for a long
            // stretch, so the block backs up and has to stall incoming requests.
            if (p == 2) begin
                write_reg(CFG_LENGTH, 1);
                @(posedge i_clk);
                hold_off_start <= 1'b1;
                @(posedge i_clk);
                hold_off_start <= 1'b0;
            end

            for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
                queue_frame(make_sample(style, k), make_sample(style, k));
            end
            wait_idle();
        end

        if (mismatch_count == 0 && bucket_results_due.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
